// ----- rtl/lge_pkg.sv -----
// Shared types and constants for the life grid generation engine.
package lge_pkg;

  localparam int CELL_W      = 64;
  localparam int ROW_INDEX_W = 6;
  localparam int OP_W        = 2;

  // Operation codes
  localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
  localparam logic [OP_W-1:0] OP_STEP  = 2'd1;
  localparam logic [OP_W-1:0] OP_READ  = 2'd2;

  // B3/S23 neighbor counts
  localparam logic [3:0] LIVE_BIRTH = 4'd3;
  localparam logic [3:0] LIVE_KEEP  = 4'd2;

  typedef struct packed {
    logic [OP_W-1:0]        operation;
    logic [ROW_INDEX_W-1:0] row_index;
    logic [CELL_W-1:0]      row_cells;
  } lge_req_t;

  typedef struct packed {
    logic [CELL_W-1:0] read_cells;
    logic              read_valid;
  } lge_rsp_t;

endpackage

// ----- rtl/lge_lane.sv -----
// One cell lane: applies the B3/S23 rule to a cell and its eight neighbors.
module lge_lane (
  input  logic       self_cell,
  input  logic [7:0] nbrs,
  output logic       next_cell
);
  import lge_pkg::*;

  logic [3:0] live;

  // Count live neighbors
  always_comb begin
    live = '0;
    for (int k = 0; k < 8; k++) begin
      live = live + 4'(nbrs[k]);
    end
  end

  // Birth on three, survival on two or three
  assign next_cell = (live == LIVE_BIRTH) || ((live == LIVE_KEEP) && self_cell);

endmodule

// ----- rtl/lge_row_merge.sv -----
// Row of cell lanes plus the merge of their outputs into the next row word.
module lge_row_merge #(
  parameter int COLS = 64
) (
  input  logic [COLS-1:0] above,
  input  logic [COLS-1:0] cur,
  input  logic [COLS-1:0] below,
  output logic [COLS-1:0] next_row
);
  import lge_pkg::*;

  // Pad with dead cells on both edges
  logic [COLS+1:0] above_pad;
  logic [COLS+1:0] cur_pad;
  logic [COLS+1:0] below_pad;
  logic [COLS-1:0] lane_out;

  assign above_pad = {1'b0, above, 1'b0};
  assign cur_pad   = {1'b0, cur, 1'b0};
  assign below_pad = {1'b0, below, 1'b0};

  // One lane per column
  for (genvar j = 0; j < COLS; j++) begin : g_lane
    lge_lane u_lane (
      .self_cell (cur[j]),
      .nbrs      ({above_pad[j], above_pad[j+1], above_pad[j+2],
                   cur_pad[j], cur_pad[j+2],
                   below_pad[j], below_pad[j+1], below_pad[j+2]}),
      .next_cell (lane_out[j])
    );
  end

  // Merge lane results into the row word
  assign next_row = lane_out;

endmodule

// ----- rtl/life_grid_generation_engine.sv -----
// Top level: grid memory, row sweep sequencer, output register.
// Write item: result in the cycle after accept. Read item: ST_READ, then the result register.
// Generation item: result in the cycle after accept; the sweep reads one row per cycle
// through the single memory read port and holds off the next item until the sweep ends.
// Reset (synchronous, active high) starts a clearing pass that writes every row dead;
// no item is accepted until it finishes.
module life_grid_generation_engine #(
  parameter int GRID_ROWS = 64,
  parameter int GRID_COLS = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_stall,
  input  lge_pkg::lge_req_t req,
  output logic              rsp_valid,
  input  logic              rsp_stall,
  output lge_pkg::lge_rsp_t rsp
);
  import lge_pkg::*;

  localparam int ROW_W = (GRID_ROWS > 1) ? $clog2(GRID_ROWS) : 1;
  localparam int CNT_W = $clog2(GRID_ROWS + 2);
  localparam int IDX_W = (ROW_W > ROW_INDEX_W) ? ROW_W : ROW_INDEX_W;
  localparam int CMP_W = IDX_W + 1;

  typedef enum logic [3:0] {
    ST_CLEAR = 4'b0001,
    ST_IDLE  = 4'b0010,
    ST_READ  = 4'b0100,
    ST_STEP  = 4'b1000
  } state_t;

  state_t             state;
  logic [CNT_W-1:0]   cnt;
  logic [GRID_COLS-1:0] mem [GRID_ROWS];
  logic [GRID_COLS-1:0] rd_data;
  logic [GRID_COLS-1:0] above_row;
  logic [GRID_COLS-1:0] cur_row;
  logic [GRID_COLS-1:0] incoming;
  logic [GRID_COLS-1:0] new_row;
  logic                 rd_in_range;

  logic               req_fire;
  logic               rsp_free;
  logic               rsp_load;
  logic [CMP_W-1:0]   idx_ext;
  logic               in_range;
  logic [ROW_W-1:0]   idx_addr;
  logic [CNT_W-1:0]   cnt_lag;
  logic               we;
  logic [ROW_W-1:0]   wr_addr;
  logic [GRID_COLS-1:0] wr_data;
  logic [ROW_W-1:0]   rd_addr;

  // Handshake
  assign rsp_free  = !rsp_valid || !rsp_stall;
  assign req_stall = (state != ST_IDLE) || !rsp_free;
  assign req_fire  = req_valid && !req_stall;

  // Raise a result at accept for non-read items, and from ST_READ for reads
  assign rsp_load = (state == ST_READ) ||
                    (req_fire && (req.operation != OP_READ));

  // Row index range check
  assign idx_ext  = CMP_W'(req.row_index);
  assign in_range = idx_ext < CMP_W'(GRID_ROWS);
  assign idx_addr = in_range ? idx_ext[ROW_W-1:0] : '0;

  // Sweep window: row below comes from memory, dead past the last row
  assign cnt_lag  = cnt - CNT_W'(2);
  assign incoming = (cnt <= CNT_W'(GRID_ROWS)) ? rd_data : '0;

  lge_row_merge #(.COLS(GRID_COLS)) u_merge (
    .above    (above_row),
    .cur      (cur_row),
    .below    (incoming),
    .next_row (new_row)
  );

  // Select memory port addresses and write data
  always_comb begin
    we      = 1'b0;
    wr_addr = '0;
    wr_data = '0;
    rd_addr = '0;
    case (state)
      ST_CLEAR: begin
        we      = 1'b1;
        wr_addr = cnt[ROW_W-1:0];
      end
      ST_IDLE: begin
        rd_addr = idx_addr;
        if (req_fire && (req.operation == OP_WRITE) && in_range) begin
          we      = 1'b1;
          wr_addr = idx_addr;
          wr_data = req.row_cells[GRID_COLS-1:0];
        end
      end
      ST_STEP: begin
        if (cnt < CNT_W'(GRID_ROWS)) begin
          rd_addr = cnt[ROW_W-1:0];
        end
        if (cnt >= CNT_W'(2)) begin
          we      = 1'b1;
          wr_addr = cnt_lag[ROW_W-1:0];
          wr_data = new_row;
        end
      end
      default: begin
        rd_addr = '0;
      end
    endcase
  end

  // Grid memory, registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      cnt       <= '0;
      rsp_valid <= 1'b0;
    end else begin
      // Raise the result on a new item, drop it once taken
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        ST_CLEAR: begin
          if (cnt == CNT_W'(GRID_ROWS - 1)) begin
            state <= ST_IDLE;
            cnt   <= '0;
          end else begin
            cnt <= cnt + CNT_W'(1);
          end
        end
        ST_IDLE: begin
          if (req_fire) begin
            case (req.operation)
              OP_READ: begin
                state <= ST_READ;
              end
              OP_STEP: begin
                state <= ST_STEP;
                cnt   <= '0;
              end
              default: begin
                state <= ST_IDLE;
              end
            endcase
          end
        end
        ST_READ: begin
          state <= ST_IDLE;
        end
        ST_STEP: begin
          if (cnt == CNT_W'(GRID_ROWS + 1)) begin
            state <= ST_IDLE;
            cnt   <= '0;
          end else begin
            cnt <= cnt + CNT_W'(1);
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Result payload and sweep window
  always_ff @(posedge clk) begin
    if ((state == ST_IDLE) && req_fire) begin
      rsp         <= '0;
      rd_in_range <= in_range;
      above_row   <= '0;
      cur_row     <= '0;
    end
    if (state == ST_READ) begin
      rsp.read_valid <= 1'b1;
      rsp.read_cells <= rd_in_range ? CELL_W'(rd_data) : '0;
    end
    if ((state == ST_STEP) && (cnt != '0)) begin
      above_row <= cur_row;
      cur_row   <= incoming;
    end
  end

  a_read_result: assert property (@(posedge clk) disable iff (rst)
    (state == ST_READ) |=> rsp_valid)
    else $error("read did not produce a result");

  a_rsp_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp.read_valid) |-> (rsp.read_cells == '0))
    else $error("non-read result carries cells");

  a_step_start: assert property (@(posedge clk) disable iff (rst)
    $rose(state == ST_STEP) |-> (cnt == '0))
    else $error("sweep did not start at row zero");

  a_step_end: assert property (@(posedge clk) disable iff (rst)
    ((state == ST_STEP) && (cnt == CNT_W'(GRID_ROWS + 1))) |=> (state == ST_IDLE))
    else $error("sweep overran its length");

  a_hold_input: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp_stall) |-> req_stall)
    else $error("item accepted while result blocked");

endmodule

// ----- sim/life_grid_generation_engine_tb.sv -----
// Testbench for the life grid generation engine: directed and random items vs a grid predictor.
`timescale 1ns / 100ps

module life_grid_generation_engine_tb;
  import lge_pkg::*;

  localparam int ROWS        = 64;
  localparam int COLS        = 64;
  localparam int ITEM_GOAL   = 800;
  localparam int LONG_HOLD   = 300;
  localparam int CYCLE_LIMIT = 400000;
  localparam logic [OP_W-1:0]   OP_UNUSED = 2'd3;
  localparam logic [CELL_W-1:0] COL_MASK  = {CELL_W{1'b1}} >> (CELL_W - COLS);

  logic     clk       = 1'b0;
  logic     rst       = 1'b1;
  logic     req_valid = 1'b0;
  logic     req_stall;
  lge_req_t req       = '0;
  logic     rsp_valid;
  logic     rsp_stall = 1'b0;
  lge_rsp_t rsp;

  // predicted grid and the results still owed by the block
  logic [CELL_W-1:0] grid_model [ROWS];
  lge_rsp_t          pending_rsp [$];

  int   error_count       = 0;
  int   items_sent        = 0;
  int   burst_left        = 0;
  bit   offering          = 1'b0;
  bit   long_hold_pending = 1'b0;
  int   cycle_count       = 0;

  life_grid_generation_engine #(
    .GRID_ROWS(ROWS),
    .GRID_COLS(COLS)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req      (req),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp      (rsp)
  );

  always #1 clk = ~clk;

  // Compute one row of the next generation from the old rows around it.
  function automatic logic [CELL_W-1:0] next_row(input logic [CELL_W-1:0] above,
                                                 input logic [CELL_W-1:0] mid,
                                                 input logic [CELL_W-1:0] below);
    logic [CELL_W-1:0] result;
    int live;
    result = '0;
    for (int c = 0; c < COLS; c++) begin
      live = 0;
      for (int dc = -1; dc <= 1; dc++) begin
        if (c + dc >= 0 && c + dc < COLS) begin
          live += int'(above[c+dc]) + int'(below[c+dc]);
          if (dc != 0) live += int'(mid[c+dc]);
        end
      end
      if (live == LIVE_BIRTH || (live == LIVE_KEEP && mid[c])) result[c] = 1'b1;
    end
    return result;
  endfunction

  // Apply one item to the predicted grid and return the result it owes.
  function automatic lge_rsp_t grid_apply(input lge_req_t item);
    lge_rsp_t          result;
    logic [CELL_W-1:0] old_rows [ROWS];
    logic [CELL_W-1:0] above, below;
    result = '0;
    case (item.operation)
      OP_WRITE: begin
        if (item.row_index < ROWS) grid_model[item.row_index] = item.row_cells & COL_MASK;
      end
      OP_STEP: begin
        old_rows = grid_model;
        for (int r = 0; r < ROWS; r++) begin
          above = (r > 0) ? old_rows[r-1] : '0;
          below = (r < ROWS - 1) ? old_rows[r+1] : '0;
          grid_model[r] = next_row(above, old_rows[r], below) & COL_MASK;
        end
      end
      OP_READ: begin
        result.read_valid = 1'b1;
        if (item.row_index < ROWS) result.read_cells = grid_model[item.row_index] & COL_MASK;
      end
      default: ;
    endcase
    return result;
  endfunction

  function automatic lge_req_t make_item(input logic [OP_W-1:0] op,
                                         input int row,
                                         input logic [CELL_W-1:0] cells);
    lge_req_t item;
    item.operation = op;
    item.row_index = row[ROW_INDEX_W-1:0];
    item.row_cells = cells;
    return item;
  endfunction

  // Offer one item until accepted, predict its result, then idle between bursts.
  task automatic send_item(input lge_req_t item);
    int gap;
    req       <= item;
    req_valid <= 1'b1;
    offering  = 1'b1;
    do @(posedge clk); while (req_stall !== 1'b0);
    pending_rsp.push_back(grid_apply(item));
    items_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = ($urandom_range(3) == 0) ? $urandom_range(40, 80)
                                            : $urandom_range(1, 10);
      gap = $urandom_range(1, 12);
      req_valid <= 1'b0;
      offering  = 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Receiver: stall in changing modes, or hold off for a long stretch on request.
  initial begin
    int stall_mode;
    int mode_left;
    stall_mode = 0;
    mode_left  = 0;
    forever begin
      @(posedge clk);
      if (long_hold_pending) begin
        rsp_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        long_hold_pending = 1'b0;
      end else begin
        if (mode_left == 0) begin
          stall_mode = $urandom_range(3);
          mode_left  = $urandom_range(20, 120);
        end
        mode_left--;
        case (stall_mode)
          0:       rsp_stall <= 1'b0;
          1:       rsp_stall <= ($urandom_range(3) == 0);
          2:       rsp_stall <= ($urandom_range(3) != 0);
          default: rsp_stall <= 1'($urandom_range(1));
        endcase
      end
    end
  end

  // Check each accepted result against the oldest prediction.
  always @(posedge clk) begin
    lge_rsp_t want;
    if (!rst && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
      if (pending_rsp.size() == 0) begin
        $display("%0t: result with none expected, got cells %h valid %b",
                 $time, rsp.read_cells, rsp.read_valid);
        error_count++;
      end else begin
        want = pending_rsp.pop_front();
        if (rsp.read_cells !== want.read_cells) begin
          $display("%0t: read_cells mismatch, expected %h, got %h",
                   $time, want.read_cells, rsp.read_cells);
          error_count++;
        end
        if (rsp.read_valid !== want.read_valid) begin
          $display("%0t: read_valid mismatch, expected %b, got %b",
                   $time, want.read_valid, rsp.read_valid);
          error_count++;
        end
      end
    end
  end

  // Stop a hung run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Read the edge rows and a middle row of a freshly cleared grid.
  task automatic test_reset_clear();
    send_item(make_item(OP_READ, 0, '0));
    send_item(make_item(OP_READ, ROWS - 1, '1));
    send_item(make_item(OP_READ, 21, '0));
  endtask

  // Write and read back all-ones and all-zero rows at both edges and an alternating row in the middle.
  task automatic test_write_read_extremes();
    send_item(make_item(OP_WRITE, 0, '1));
    send_item(make_item(OP_WRITE, ROWS - 1, '0));
    send_item(make_item(OP_WRITE, 42, {32{2'b10}}));
    send_item(make_item(OP_READ, 0, '0));
    send_item(make_item(OP_READ, ROWS - 1, '0));
    send_item(make_item(OP_READ, 42, '0));
  endtask

  // The unused operation code must leave the grid alone.
  task automatic test_unused_op();
    send_item(make_item(OP_UNUSED, 0, '1));
    send_item(make_item(OP_READ, 0, '0));
  endtask

  // Full top row and a still block in the south-east corner across one generation.
  task automatic test_edge_generation();
    logic [CELL_W-1:0] corner;
    corner = '0;
    corner[COLS-1] = 1'b1;
    corner[COLS-2] = 1'b1;
    send_item(make_item(OP_WRITE, ROWS - 2, corner));
    send_item(make_item(OP_WRITE, ROWS - 1, corner));
    send_item(make_item(OP_STEP, 0, '0));
    send_item(make_item(OP_READ, 0, '0));
    send_item(make_item(OP_READ, 1, '0));
    send_item(make_item(OP_READ, ROWS - 2, '0));
    send_item(make_item(OP_READ, ROWS - 1, '0));
  endtask

  // Hold the receiver off while items keep coming, so the block backs up.
  task automatic test_long_stall();
    long_hold_pending = 1'b1;
    for (int i = 0; i < 24; i++) begin
      if (i % 2 == 0) begin
        send_item(make_item(OP_WRITE, $urandom_range(ROWS - 1), {$urandom, $urandom}));
      end else begin
        send_item(make_item(OP_READ, $urandom_range(ROWS - 1), '0));
      end
    end
  endtask

  // Mostly write-advance-read sequences on patches of the grid, with some noise.
  task automatic test_random_patterns();
    int base;
    int height;
    int steps;
    while (items_sent < ITEM_GOAL) begin
      if ($urandom_range(9) < 7) begin
        height = $urandom_range(2, 6);
        case ($urandom_range(3))
          0:       base = 0;
          1:       base = ROWS - height;
          default: base = $urandom_range(ROWS - height);
        endcase
        for (int i = 0; i < height; i++) begin
          send_item(make_item(OP_WRITE, base + i,
                              {$urandom, $urandom} & {$urandom, $urandom}));
        end
        steps = $urandom_range(1, 3);
        repeat (steps) begin
          send_item(make_item(OP_STEP, $urandom_range(ROWS - 1), {$urandom, $urandom}));
        end
        for (int r = base - 1; r <= base + height; r++) begin
          if (r >= 0 && r < ROWS) send_item(make_item(OP_READ, r, {$urandom, $urandom}));
        end
      end else begin
        send_item(make_item(OP_W'($urandom_range(3)), $urandom_range(ROWS - 1),
                            {$urandom, $urandom}));
      end
    end
  endtask

  initial begin
    // the block comes out of reset with every cell dead
    foreach (grid_model[r]) grid_model[r] = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_clear();
    test_write_read_extremes();
    test_unused_op();
    test_edge_generation();
    test_long_stall();
    test_random_patterns();

    // drop valid, drain, then let a full sweep pass
    if (offering) begin
      req_valid <= 1'b0;
      offering  = 1'b0;
    end
    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (ROWS + 8) @(posedge clk);

    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/lge_pkg.sv
rtl/lge_lane.sv
rtl/lge_row_merge.sv
rtl/life_grid_generation_engine.sv
sim/life_grid_generation_engine_tb.sv
